// ----- sv/lphs_pkg.sv -----
`timescale 1ns / 1ps
package lphs_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KEY_W = 16;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [KEY_W-1:0] key_t;
	typedef logic [1:0]       sstate_t;
	typedef logic [2:0]       status_t;
	typedef logic [3:0]       slot_t;

	localparam sstate_t SS_EMPTY    = 2'd0;
	localparam sstate_t SS_OCCUPIED = 2'd1;
	localparam sstate_t SS_DELETED  = 2'd2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam status_t RES_INSERTED  = 3'd0;
	localparam status_t RES_DUPLICATE = 3'd1;
	localparam status_t RES_FULL      = 3'd2;
	localparam status_t RES_DELETED   = 3'd3;
	localparam status_t RES_NOT_FOUND = 3'd4;

	localparam idx_t IDX_LAST = idx_t'(SLOTS - 1);

	typedef struct packed {
		logic    en;
		logic    key_en;
		idx_t    addr;
		key_t    key;
		sstate_t st;
	} tbl_wr_t;

	function automatic slot_t to_slot(input idx_t idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[3:0];
	endfunction

endpackage

// ----- sv/linear_probe_hash_set.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload                                  Handshake
// s_axis    in         tuser[0] cmd, tdata[15:0] key            s_tvalid/s_tready
// m_axis    out        tdata[2:0] status, tdata[6:3] slot       m_tvalid/m_tready
//
// An item is accepted in IDLE, probed in PROBE until the probe walk over the slot table ends,
// and held in RESP until its result is handed over to the output register.
// Reset marks every slot empty at once, so no clearing pass is needed.
// A result waits in the output register while the next item is accepted and probed.
// A stalled output holds the finished next result in the sequencer until the register frees.
module linear_probe_hash_set
	import lphs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // key [15:0]
	input  logic [0:0]  s_tuser,  // cmd [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // status [2:0], slot [6:3], zero [7]
);

	idx_t    rd_addr;
	sstate_t rd_state;
	key_t    rd_key;
	tbl_wr_t wr;
	logic    res_valid;
	logic    res_ready;
	status_t res_status;
	slot_t   res_slot;
	logic    m_tvalid_q;
	status_t status_q;
	slot_t   slot_q;

	lphs_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_state (rd_state),
		.rd_key   (rd_key),
		.wr       (wr)
	);

	lphs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser[0]),
		.in_key     (s_tdata),
		.rd_addr    (rd_addr),
		.rd_state   (rd_state),
		.rd_key     (rd_key),
		.wr         (wr),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_status (res_status),
		.res_slot   (res_slot)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			status_q <= res_status;
			slot_q   <= res_slot;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, slot_q, status_q};

endmodule

// ----- sv/lphs_table.sv -----
`timescale 1ns / 1ps
module lphs_table
	import lphs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  idx_t    rd_addr,
	output sstate_t rd_state,
	output key_t    rd_key,
	input  tbl_wr_t wr
);

	key_t    keys_q   [SLOTS];
	sstate_t states_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				states_q[i] <= SS_EMPTY;
			end
		end else if (wr.en) begin
			states_q[wr.addr] <= wr.st;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.key_en) begin
			keys_q[wr.addr] <= wr.key;
		end
	end

	assign rd_state = states_q[rd_addr];
	assign rd_key   = keys_q[rd_addr];

endmodule

// ----- sv/lphs_ctrl.sv -----
`timescale 1ns / 1ps
module lphs_ctrl
	import lphs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    in_cmd,
	input  key_t    in_key,
	output idx_t    rd_addr,
	input  sstate_t rd_state,
	input  key_t    rd_key,
	output tbl_wr_t wr,
	output logic    res_valid,
	input  logic    res_ready,
	output status_t res_status,
	output slot_t   res_slot
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_RESP  = 2'd2;

	logic [1:0] state_q;
	logic       cmd_q;
	key_t       key_q;
	idx_t       idx_q;
	idx_t       cnt_q;
	status_t    status_q;
	slot_t      slot_q;

	logic    occ;
	logic    hit;
	logic    last;
	logic    done;
	status_t status_n;
	idx_t    idx_next;

	assign occ      = (rd_state == SS_OCCUPIED);
	assign hit      = (rd_key == key_q);
	assign last     = (cnt_q == IDX_LAST);
	assign idx_next = (idx_q == IDX_LAST) ? '0 : idx_q + idx_t'(1);
	assign rd_addr  = idx_q;

	always_comb begin
		done     = 1'b0;
		status_n = RES_NOT_FOUND;
		wr       = '0;
		wr.addr  = idx_q;
		wr.key   = key_q;
		if (state_q == ST_PROBE) begin
			if (cmd_q == CMD_INSERT) begin
				priority if (!occ) begin
					done      = 1'b1;
					status_n  = RES_INSERTED;
					wr.en     = 1'b1;
					wr.key_en = 1'b1;
					wr.st     = SS_OCCUPIED;
				end else if (hit) begin
					done     = 1'b1;
					status_n = RES_DUPLICATE;
				end else if (last) begin
					done     = 1'b1;
					status_n = RES_FULL;
				end else begin
					done     = 1'b0;
				end
			end else begin
				priority if (occ && hit) begin
					done     = 1'b1;
					status_n = RES_DELETED;
					wr.en    = 1'b1;
					wr.st    = SS_DELETED;
				end else if (last) begin
					done     = 1'b1;
					status_n = RES_NOT_FOUND;
				end else begin
					done     = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
			idx_q <= idx_t'(in_key % SLOTS);
			cnt_q <= '0;
		end else if (state_q == ST_PROBE) begin
			if (done) begin
				status_q <= status_n;
				slot_q   <= (wr.en) ? to_slot(idx_q) : '0;
			end else begin
				idx_q <= idx_next;
				cnt_q <= cnt_q + idx_t'(1);
			end
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_RESP);
	assign res_status = status_q;
	assign res_slot   = slot_q;

endmodule

// ----- sv/lphs_checker.sv -----
`timescale 1ns / 1ps
module lphs_props
	import lphs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again while an item is in work");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] == RES_INSERTED || m_tdata[2:0] == RES_DUPLICATE ||
			m_tdata[2:0] == RES_FULL || m_tdata[2:0] == RES_DELETED ||
			m_tdata[2:0] == RES_NOT_FOUND) && !m_tdata[7])
		else $error("output status code out of range");

	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == RES_DUPLICATE || m_tdata[2:0] == RES_FULL ||
			m_tdata[2:0] == RES_NOT_FOUND) |-> m_tdata[6:3] == 4'd0)
		else $error("failed operation reports a nonzero slot");

endmodule

bind linear_probe_hash_set lphs_props u_lphs_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- bench/lphs_checker.sv -----
`timescale 1ns / 1ps
module lphs_checker
	import lphs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // key [15:0]
	input  logic [0:0]  s_tuser,  // cmd [0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // status [2:0], slot [6:3], zero [7]
	output int          errors,
	output int          pending
);

	typedef struct packed {
		status_t status;
		slot_t   slot;
	} hash_result_t;

	key_t         table_keys  [SLOTS];
	sstate_t      table_marks [SLOTS];
	hash_result_t expected_q  [$];
	int           mismatches = 0;

	assign errors = mismatches;

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	// Walks the probe run of one key and updates the local copy of the table.
	function automatic hash_result_t apply_hash_op(input logic op, input key_t k);
		hash_result_t r;
		idx_t         pos;
		r.status = (op == CMD_INSERT) ? RES_FULL : RES_NOT_FOUND;
		r.slot   = '0;
		pos      = idx_t'(k % SLOTS);
		for (int n = 0; n < SLOTS; n++) begin
			if (op == CMD_INSERT) begin
				if (table_marks[pos] != SS_OCCUPIED) begin
					table_keys[pos]  = k;
					table_marks[pos] = SS_OCCUPIED;
					r.status         = RES_INSERTED;
					r.slot           = slot_t'(pos);
					break;
				end
				if (table_keys[pos] == k) begin
					r.status = RES_DUPLICATE;
					break;
				end
			end else if (table_marks[pos] == SS_OCCUPIED && table_keys[pos] == k) begin
				table_marks[pos] = SS_DELETED;
				r.status         = RES_DELETED;
				r.slot           = slot_t'(pos);
				break;
			end
			pos = (pos == IDX_LAST) ? '0 : idx_t'(pos + 1'b1);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hash_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) table_marks[i] = SS_EMPTY;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no item outstanding", 0, m_tdata);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[2:0] != want.status)
						report_mismatch("status", want.status, m_tdata[2:0]);
					if (m_tdata[6:3] != want.slot)
						report_mismatch("slot", want.slot, m_tdata[6:3]);
					if (m_tdata[7] != 1'b0)
						report_mismatch("pad bit", 0, m_tdata[7]);
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(apply_hash_op(s_tuser[0], key_t'(s_tdata)));
			pending <= expected_q.size();
		end
	end

endmodule

// ----- bench/linear_probe_hash_set_test.sv -----
`timescale 1ns / 1ps
module linear_probe_hash_set_test;
	import lphs_pkg::*;

	localparam int HOLD_LEN = 300;
	localparam int POOL_N   = 32;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;

	int          errors;
	int          pending;
	int          idle_pct  = 0;
	int          stall_pct = 0;
	logic        hold_req  = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;
	key_t        key_pool [POOL_N];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	linear_probe_hash_set DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lphs_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// A toggle of hold_req starts one long stall of the result channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic offer_item(input logic op, input key_t k);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= k;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic key_t pick_key();
		if ($urandom_range(99) < 60) return key_pool[$urandom_range(POOL_N - 1)];
		return key_t'($urandom_range(65535));
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 55) offer_item(CMD_INSERT, pick_key());
			else offer_item(CMD_DELETE, pick_key());
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < POOL_N; i++)
			key_pool[i] = key_t'(($urandom_range(4095) << 4) | (i % 16));
		key_pool[0]  = 16'h0000;
		key_pool[16] = 16'h0010;
		key_pool[31] = 16'hFFFF;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_item(CMD_INSERT, 16'h0000);
		offer_item(CMD_INSERT, 16'hFFFF);
		offer_item(CMD_INSERT, 16'h0000);
		offer_item(CMD_DELETE, 16'hFFFF);
		offer_item(CMD_DELETE, 16'hFFFF);
		offer_item(CMD_INSERT, 16'hFFFF);
		offer_item(CMD_INSERT, 16'h0010);
		offer_item(CMD_DELETE, 16'h0000);
		// The tombstone at the home slot hides the copy of the key one slot on.
		offer_item(CMD_INSERT, 16'h0010);
		for (int i = 2; i <= 14; i++) offer_item(CMD_INSERT, key_pool[i]);
		// The table is now full.
		offer_item(CMD_INSERT, 16'h0020);
		offer_item(CMD_DELETE, 16'h0000);
		offer_item(CMD_INSERT, 16'hFFFF);
		drain_results();

		hold_req <= ~hold_req;
		run_random(12);
		drain_results();

		run_random(180);
		drain_results();

		idle_pct = 84;
		run_random(190);
		drain_results();

		idle_pct = 0;
		stall_pct <= 84;
		run_random(190);
		drain_results();

		idle_pct = 28;
		stall_pct <= 28;
		run_random(190);
		drain_results();

		repeat (2 * (SLOTS + 2)) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
